// ===== src/tsd_pkg.sv =====
// shared types, constants and helpers for the touch event and swipe detector
// no dependencies; compiled first

package tsd_pkg;

    localparam int COORD_BITS = 14;
    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SLOT_BITS  = 8;
    localparam int THR_BITS   = 8;
    localparam int DIST_BITS  = 15;
    localparam int MAX_RES    = 3;
    localparam int CNT_BITS   = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [COORD_BITS-1:0] COORD_MASK = {COORD_BITS{1'b1}};
    localparam logic [THR_BITS-1:0]   THR_RESET  = THR_BITS'(2);
    localparam logic [DIST_BITS-1:0]  DIST_RESET = DIST_BITS'(10);

    // register indexes on the config port
    typedef enum logic
    {
        REG_MOVE_THRESHOLD = 1'b0,
        REG_GESTURE_MIN    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        EV_DOWN    = 2'd0,
        EV_MOVE    = 2'd1,
        EV_UP      = 2'd2,
        EV_GESTURE = 2'd3
    } evt_kind_t;

    typedef enum logic [2:0]
    {
        DIR_E  = 3'd0,
        DIR_W  = 3'd1,
        DIR_S  = 3'd2,
        DIR_N  = 3'd3,
        DIR_SE = 3'd4,
        DIR_NE = 3'd5,
        DIR_SW = 3'd6,
        DIR_NW = 3'd7
    } dir_t;

    typedef struct packed
    {
        evt_kind_t              kind;
        dir_t                   dir;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [SLOT_BITS-1:0]   slot;
        logic                   last;
    } res_t;

    typedef struct packed
    {
        res_t [MAX_RES-1:0]     res;
        logic [CNT_BITS-1:0]    cnt;
    } bundle_t;

    // tracker state; move count only needs to know "more than two"
    typedef struct packed
    {
        logic                   was_down;
        logic [COORD_BITS-1:0]  prev_x;
        logic [COORD_BITS-1:0]  prev_y;
        logic [COORD_BITS-1:0]  start_x;
        logic [COORD_BITS-1:0]  start_y;
        logic [1:0]             mcnt;
        logic [RING_AW-1:0]     tail;
        logic [RING_AW-1:0]     head;
    } st_t;

    localparam st_t ST_RESET = '{
        was_down: 1'b0,
        prev_x:   COORD_MASK,
        prev_y:   COORD_MASK,
        start_x:  COORD_MASK,
        start_y:  COORD_MASK,
        mcnt:     2'd0,
        tail:     '0,
        head:     '0
    };

endpackage

// ===== src/tsd_if.sv =====
// handshake channels for touch samples and result events
// depends on tsd_pkg

interface tsd_sample_if;
    import tsd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   touching;
    logic [COORD_BITS-1:0]  touch_x;
    logic [COORD_BITS-1:0]  touch_y;

    modport source (output valid, touching, touch_x, touch_y, input ready);
    modport sink   (input valid, touching, touch_x, touch_y, output ready);
endinterface

interface tsd_event_if;
    import tsd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             event_kind;
    logic [2:0]             direction;
    logic [COORD_BITS-1:0]  point_x;
    logic [COORD_BITS-1:0]  point_y;
    logic [SLOT_BITS-1:0]   slot;
    logic                   last;

    modport source (output valid, event_kind, direction, point_x, point_y, slot, last,
                    input ready);
    modport sink   (input valid, event_kind, direction, point_x, point_y, slot, last,
                    output ready);
endinterface

// ===== src/tsd_core.sv =====
// combinational event logic: one sample plus tracker state gives next state
// and up to three result beats; depends on tsd_pkg

module tsd_core
(
    input  tsd_pkg::st_t                          st,
    input  logic                                  touching,
    input  logic [tsd_pkg::COORD_BITS-1:0]        touch_x,
    input  logic [tsd_pkg::COORD_BITS-1:0]        touch_y,
    input  logic [tsd_pkg::THR_BITS-1:0]          move_threshold,
    input  logic [tsd_pkg::DIST_BITS-1:0]         gesture_min_distance,
    output tsd_pkg::st_t                          st_next,
    output tsd_pkg::bundle_t                      bundle
);
    import tsd_pkg::*;

    function automatic logic [COORD_BITS-1:0] absdiff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [RING_AW-1:0] ring_adv(input logic [RING_AW-1:0] p);
        return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [COORD_BITS-1:0]  adx_p;
    logic [COORD_BITS-1:0]  ady_p;
    logic [COORD_BITS-1:0]  adx_s;
    logic [COORD_BITS-1:0]  ady_s;
    logic [COORD_BITS-1:0]  thr;
    logic [DIST_BITS-1:0]   swipe_len;
    logic                   past_thr;
    logic                   diag;
    logic                   x_pos;
    logic                   y_pos;
    dir_t                   dir;
    logic [RING_AW-1:0]     tail_adv;
    logic [RING_AW-1:0]     head_adv;
    logic [SLOT_BITS-1:0]   slot_cur;
    res_t                   r_down;
    res_t                   r_move;
    res_t                   r_up;
    res_t                   r_gest;

    assign thr       = COORD_BITS'(move_threshold);
    assign adx_p     = absdiff(touch_x, st.prev_x);
    assign ady_p     = absdiff(touch_y, st.prev_y);
    assign adx_s     = absdiff(touch_x, st.start_x);
    assign ady_s     = absdiff(touch_y, st.start_y);
    assign past_thr  = (adx_p > thr) && (ady_p > thr);
    assign swipe_len = DIST_BITS'(adx_s) + DIST_BITS'(ady_s);
    assign x_pos     = touch_x > st.start_x;
    assign y_pos     = touch_y > st.start_y;

    // eight-way classification around the swipe start point
    always_comb
    begin
        if (adx_s > ady_s)
            diag = (adx_s - ady_s) <= (adx_s >> 1);
        else
            diag = (ady_s - adx_s) <= (ady_s >> 1);

        if (diag)
            dir = x_pos ? (y_pos ? DIR_SE : DIR_NE) : (y_pos ? DIR_SW : DIR_NW);
        else if (adx_s > ady_s)
            dir = x_pos ? DIR_E : DIR_W;
        else
            dir = y_pos ? DIR_S : DIR_N;
    end

    // at most one point is stored per sample
    assign tail_adv = ring_adv(st.tail);
    assign head_adv = (tail_adv == st.head) ? ring_adv(st.head) : st.head;
    assign slot_cur = SLOT_BITS'(st.tail);

    always_comb
    begin
        r_down = '{kind: EV_DOWN, dir: DIR_E, x: touch_x, y: touch_y,
                   slot: slot_cur, last: 1'b0};
        r_move = '{kind: EV_MOVE, dir: DIR_E, x: touch_x, y: touch_y,
                   slot: slot_cur, last: 1'b0};
        r_up   = '{kind: EV_UP, dir: DIR_E, x: touch_x, y: touch_y,
                   slot: slot_cur, last: 1'b0};
        r_gest = '{kind: EV_GESTURE, dir: dir, x: st.start_x, y: st.start_y,
                   slot: '0, last: 1'b0};
    end

    always_comb
    begin
        st_next    = st;
        bundle.res = '0;
        bundle.cnt = '0;

        priority if (touching && !st.was_down)
        begin
            st_next.was_down = 1'b1;
            st_next.prev_x   = touch_x;
            st_next.prev_y   = touch_y;
            st_next.start_x  = touch_x;
            st_next.start_y  = touch_y;
            st_next.tail     = tail_adv;
            st_next.head     = head_adv;
            bundle.res[0]    = r_down;
            bundle.cnt       = CNT_BITS'(1);
        end
        else if (touching && st.was_down)
        begin
            if (st.mcnt != 2'd3)
                st_next.mcnt = st.mcnt + 2'd1;
            if (past_thr)
            begin
                st_next.prev_x = touch_x;
                st_next.prev_y = touch_y;
                st_next.tail   = tail_adv;
                st_next.head   = head_adv;
                bundle.res[0]  = r_move;
                bundle.cnt     = CNT_BITS'(1);
            end
        end
        else if (!touching && st.was_down)
        begin
            st_next.was_down = 1'b0;
            st_next.prev_x   = touch_x;
            st_next.prev_y   = touch_y;
            st_next.tail     = tail_adv;
            st_next.head     = head_adv;
            // release move: compared against the point before it is replaced
            if ((st.mcnt == 2'd3) && past_thr)
            begin
                st_next.mcnt  = 2'd0;
                bundle.res[0] = r_move;
                bundle.res[1] = r_up;
                bundle.res[2] = r_gest;
                bundle.cnt    = (swipe_len >= gesture_min_distance) ? CNT_BITS'(3)
                                                                    : CNT_BITS'(2);
            end
            else
            begin
                bundle.res[0] = r_up;
                bundle.res[1] = r_gest;
                bundle.cnt    = (swipe_len >= gesture_min_distance) ? CNT_BITS'(2)
                                                                    : CNT_BITS'(1);
            end
        end
        else
        begin
            // idle sample, nothing to report
            bundle.cnt = '0;
        end

        for (int i = 0; i < MAX_RES; i++)
            bundle.res[i].last = (CNT_BITS'(i + 1) == bundle.cnt);
    end

endmodule

// ===== src/touch_event_and_swipe_detector.sv =====
// touch event and swipe detector top level: config registers, tracker state,
// result beat queue; depends on tsd_pkg, tsd_if.sv and tsd_core
//
// usage
// - sample channel (tsd_sample_if sink): one touch sample per beat, a contact
//   flag and x/y coordinates
// - event channel (tsd_event_if source): down, move, up and gesture events,
//   zero to three beats per sample, the final beat of a sample flagged by last
// - apb port: move_threshold at 0x0, gesture_min_distance at 0x4; write only
//   while the block is idle; reads return the current values
// timing and throughput
// - the first event of a sample is registered, shown in the cycle after the sample beat
// - the result queue drains one event beat per cycle unless the receiver
//   stalls, and takes the next sample in the same cycle as its final beat
//   leaves, so samples giving at most one event stream at one per cycle; a
//   release with move, up and gesture holds the sample side until all leave
// reset
// - rst_n clears the tracker (not touched, start/prev points all ones, ring
//   tail and head at slot 0), empties the queue and loads register defaults
//   (threshold 2, minimum distance 10); no clearing pass is needed
// backpressure
// - while the event receiver stalls the queued event beat holds steady and
//   the sample side stays not ready once the pending sample's last beat waits

module touch_event_and_swipe_detector
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsd_pkg::APB_AW-1:0]  paddr,
    input  logic [tsd_pkg::APB_DW-1:0]  pwdata,
    output logic [tsd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    tsd_sample_if.sink                  sample,
    tsd_event_if.source                 evt
);
    import tsd_pkg::*;

    // config registers
    logic [THR_BITS-1:0]    thr_reg;
    logic [DIST_BITS-1:0]   gmd_reg;
    logic                   cfg_wr;
    reg_idx_t               cfg_idx;

    // tracker state
    st_t                    st_reg;
    st_t                    st_next;

    // result queue: beat 0 is on the port, later beats shift down
    res_t [MAX_RES-1:0]     res_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    bundle_t                bundle;

    logic                   in_fire;
    logic                   out_fire;

    // apb: byte lanes within a word are ignored, word index picks the register
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_MOVE_THRESHOLD: prdata = APB_DW'(thr_reg);
            REG_GESTURE_MIN:    prdata = APB_DW'(gmd_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            gmd_reg <= DIST_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MOVE_THRESHOLD: thr_reg <= pwdata[THR_BITS-1:0];
                REG_GESTURE_MIN:    gmd_reg <= pwdata[DIST_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // handshakes: a new sample enters when the queue is empty or its final
    // beat leaves in this cycle
    assign out_fire     = evt.valid && evt.ready;
    assign sample.ready = (cnt_reg == '0) || ((cnt_reg == CNT_BITS'(1)) && evt.ready);
    assign in_fire      = sample.valid && sample.ready;

    tsd_core u_core
    (
        .st                   (st_reg),
        .touching             (sample.touching),
        .touch_x              (sample.touch_x),
        .touch_y              (sample.touch_y),
        .move_threshold       (thr_reg),
        .gesture_min_distance (gmd_reg),
        .st_next              (st_next),
        .bundle               (bundle)
    );

    // state only moves on an accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_RESET;
        else if (in_fire)
            st_reg <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (in_fire)
            cnt_reg <= bundle.cnt;
        else if (out_fire)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= bundle.res;
        else if (out_fire)
            res_reg <= {res_t'('0), res_reg[MAX_RES-1:1]};
    end

    // event port driven straight from the head of the queue
    assign evt.valid      = (cnt_reg != '0);
    assign evt.event_kind = res_reg[0].kind;
    assign evt.direction  = res_reg[0].dir;
    assign evt.point_x    = res_reg[0].x;
    assign evt.point_y    = res_reg[0].y;
    assign evt.slot       = res_reg[0].slot;
    assign evt.last       = res_reg[0].last;

    // last flag must mark exactly the final queued beat
    a_last_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid |-> (evt.last == (cnt_reg == CNT_BITS'(1))))
        else $error("last flag out of step with queue count");

    // a sample never enters while beats other than the departing last remain
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cnt_reg != '0)) |-> (out_fire && (cnt_reg == CNT_BITS'(1))))
        else $error("sample accepted over pending events");

    // gesture beats carry no ring slot
    a_gesture_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && (evt.event_kind == EV_GESTURE)) |-> (evt.slot == '0))
        else $error("gesture event with nonzero slot");

    // ring tail and contact state move only with an accepted sample
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> ($stable(st_reg.tail) && $stable(st_reg.was_down)))
        else $error("tracker state changed without a sample");

    // a gesture always closes the beats of its sample
    a_gesture_last: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && (evt.event_kind == EV_GESTURE)) |-> evt.last)
        else $error("gesture event not the final beat");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the touch event and swipe detector: directed touch
// table, then random swipes under several register settings, with stalls
// depends on tsd_pkg, tsd_if.sv and touch_event_and_swipe_detector

module tb_top;
    import tsd_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 8;
    localparam int SWIPES_PER_PHASE = 88;
    localparam int N_ROWS           = 25;
    localparam int ZERO_CFG_ROW     = 14;
    localparam int MAX_PRINTED      = 100;

    typedef logic [COORD_BITS-1:0] coord_t;

    // how a table row gets its expected events
    typedef enum logic [1:0]
    {
        ROW_PREDICT,
        ROW_NONE,
        ROW_ONE
    } row_mode_t;

    typedef struct
    {
        logic       dn;
        coord_t     x;
        coord_t     y;
        row_mode_t  mode;
        res_t       want;
    } touch_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    tsd_sample_if sample_ch ();
    tsd_event_if  event_ch ();

    touch_event_and_swipe_detector i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .evt     (event_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // gesture tracker copy: touch state, swipe start, last reported point,
    // hold counter and ring pointers, plus the two register values
    logic                   trk_down;
    coord_t                 trk_prev_x;
    coord_t                 trk_prev_y;
    coord_t                 trk_start_x;
    coord_t                 trk_start_y;
    int unsigned            trk_count;
    logic [SLOT_BITS-1:0]   ring_tail;
    logic [SLOT_BITS-1:0]   ring_head;
    logic [THR_BITS-1:0]    cfg_thr;
    logic [DIST_BITS-1:0]   cfg_gmin;

    // events still owed by the block, oldest first
    res_t                   pending_events[$];

    int                     n_errors;
    int                     n_samples;
    int                     n_live;
    int                     n_events;
    int                     n_gestures;
    int                     n_settings;
    logic [7:0]             dirs_seen;
    int                     hold_asks;
    bit                     calm;

    // directed touches; typed-in events only where they are obvious
    touch_row_t touch_rows [N_ROWS] = '{
        // release while never touched: no event at all
        '{1'b0, COORD_MASK, COORD_MASK, ROW_NONE, '0},
        // first press after reset takes ring slot 0
        '{1'b1, 14'd0, 14'd0, ROW_ONE, '{EV_DOWN, DIR_E, 14'd0, 14'd0, 8'd0, 1'b1}},
        '{1'b1, 14'd1, 14'd1, ROW_NONE, '0},
        '{1'b1, 14'd3, 14'd3, ROW_ONE, '{EV_MOVE, DIR_E, 14'd3, 14'd3, 8'd1, 1'b1}},
        // only one axis moved
        '{1'b1, 14'd3, 14'd100, ROW_NONE, '0},
        // release to the far corner: move, up and a south-east swipe
        '{1'b0, COORD_MASK, COORD_MASK, ROW_PREDICT, '0},
        '{1'b0, 14'd0, COORD_MASK, ROW_NONE, '0},
        '{1'b1, COORD_MASK, COORD_MASK, ROW_ONE,
          '{EV_DOWN, DIR_E, COORD_MASK, COORD_MASK, 8'd3, 1'b1}},
        '{1'b1, COORD_MASK, COORD_MASK, ROW_NONE, '0},
        // no motion, distance below minimum: up alone
        '{1'b0, COORD_MASK, COORD_MASK, ROW_ONE,
          '{EV_UP, DIR_E, COORD_MASK, COORD_MASK, 8'd4, 1'b1}},
        // hold count carries over from the last touch, so two holds here
        // are enough for a release move
        '{1'b1, 14'd5000, 14'd5000, ROW_ONE,
          '{EV_DOWN, DIR_E, 14'd5000, 14'd5000, 8'd5, 1'b1}},
        '{1'b1, 14'd5001, 14'd5001, ROW_NONE, '0},
        '{1'b1, 14'd5002, 14'd5002, ROW_NONE, '0},
        '{1'b0, 14'd6000, 14'd4000, ROW_PREDICT, '0},
        // from here threshold and minimum distance are both zero
        '{1'b1, 14'd8000, 14'd8000, ROW_ONE,
          '{EV_DOWN, DIR_E, 14'd8000, 14'd8000, 8'd7, 1'b1}},
        // release in place: zero distance classifies as north-west
        '{1'b0, 14'd8000, 14'd8000, ROW_PREDICT, '0},
        '{1'b1, 14'd8000, 14'd8000, ROW_PREDICT, '0},
        '{1'b0, 14'd9000, 14'd8000, ROW_PREDICT, '0},
        '{1'b1, 14'd8000, 14'd8000, ROW_PREDICT, '0},
        '{1'b0, 14'd8000, 14'd7000, ROW_PREDICT, '0},
        '{1'b1, 14'd8000, 14'd8000, ROW_PREDICT, '0},
        '{1'b0, 14'd7000, 14'd9000, ROW_PREDICT, '0},
        '{1'b1, 14'd0, COORD_MASK, ROW_PREDICT, '0},
        '{1'b1, 14'd1, 14'd16382, ROW_PREDICT, '0},
        '{1'b0, COORD_MASK, 14'd0, ROW_PREDICT, '0}
    };

    task automatic report(input string what);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
        begin
            $display("%0t ERROR %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report($sformatf("event %0d: %s is %0h, expected %0h", n_events, name, got, want));
        end
    endtask

    function automatic int unsigned span(input coord_t a, input coord_t b);
        return 32'((a > b) ? a - b : b - a);
    endfunction

    // next ring slot; the oldest entry is dropped once the tail catches it
    function automatic logic [SLOT_BITS-1:0] take_slot();
        logic [SLOT_BITS-1:0] s;
        s = ring_tail;
        ring_tail = ring_tail + 1'b1;
        if (ring_tail == ring_head)
        begin
            ring_head = ring_head + 1'b1;
        end
        return s;
    endfunction

    // advance the tracker by one sample and list the events it gives
    function automatic void track_touch(input logic dn, input coord_t x, input coord_t y,
                                        output res_t evs[$]);
        logic [SLOT_BITS-1:0]   s;
        logic                   moved;
        logic                   diag;
        int                     dx;
        int                     dy;
        int                     adx;
        int                     ady;
        dir_t                   heading;
        evs = {};
        if (dn && !trk_down)
        begin
            s = take_slot();
            trk_down = 1'b1;
            trk_prev_x = x;
            trk_prev_y = y;
            trk_start_x = x;
            trk_start_y = y;
            evs.push_back(res_t'{EV_DOWN, DIR_E, x, y, s, 1'b0});
        end
        else if (dn && trk_down)
        begin
            if (trk_count < 32'hFFFF)
            begin
                trk_count++;
            end
            if (span(x, trk_prev_x) > cfg_thr && span(y, trk_prev_y) > cfg_thr)
            begin
                s = take_slot();
                trk_prev_x = x;
                trk_prev_y = y;
                evs.push_back(res_t'{EV_MOVE, DIR_E, x, y, s, 1'b0});
            end
        end
        else if (!dn && trk_down)
        begin
            s = take_slot();
            // the move test looks at the point reported before this release
            moved = trk_count > 2 && span(x, trk_prev_x) > cfg_thr
                    && span(y, trk_prev_y) > cfg_thr;
            dx = int'(x) - int'(trk_start_x);
            dy = int'(y) - int'(trk_start_y);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            trk_down = 1'b0;
            trk_prev_x = x;
            trk_prev_y = y;
            if (moved)
            begin
                evs.push_back(res_t'{EV_MOVE, DIR_E, x, y, s, 1'b0});
                trk_count = 0;
            end
            evs.push_back(res_t'{EV_UP, DIR_E, x, y, s, 1'b0});
            if (adx + ady >= int'(cfg_gmin))
            begin
                // diagonal when the smaller axis is at least half the larger
                if (adx > ady)
                begin
                    diag = (adx - ady) <= adx / 2;
                end
                else
                begin
                    diag = (ady - adx) <= ady / 2;
                end
                if (diag)
                begin
                    heading = (dx > 0) ? ((dy > 0) ? DIR_SE : DIR_NE)
                                       : ((dy > 0) ? DIR_SW : DIR_NW);
                end
                else if (adx > ady)
                begin
                    heading = (dx > 0) ? DIR_E : DIR_W;
                end
                else
                begin
                    heading = (dy > 0) ? DIR_S : DIR_N;
                end
                evs.push_back(res_t'{EV_GESTURE, heading, trk_start_x, trk_start_y,
                                     8'd0, 1'b0});
            end
        end
        if (evs.size() > 0)
        begin
            evs[evs.size() - 1].last = 1'b1;
        end
    endfunction

    // offer one sample, wait for its beat, then record what it should give
    task automatic send_touch(input logic dn, input coord_t x, input coord_t y,
                              input row_mode_t mode = ROW_PREDICT, input res_t want = '0);
        res_t   evs[$];
        int     pause;
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            sample_ch.valid <= 1'b0;
            pause = $urandom_range(1, 4);
            repeat (pause) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.touching <= dn;
        sample_ch.touch_x <= x;
        sample_ch.touch_y <= y;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        n_samples++;
        if (dn || trk_down)
        begin
            n_live++;
        end
        track_touch(dn, x, y, evs);
        case (mode)
            ROW_PREDICT: foreach (evs[j]) pending_events.push_back(evs[j]);
            ROW_ONE:     pending_events.push_back(want);
            default:     ;
        endcase
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input reg_idx_t idx, input logic [APB_DW-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            report($sformatf("register %s reads %0h, expected %0h", idx.name(), prdata, want));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // junk above the register width must be dropped by the block
    task automatic set_config(input logic [THR_BITS-1:0] thr,
                              input logic [DIST_BITS-1:0] gmin);
        apb_write(REG_MOVE_THRESHOLD, ($urandom() << THR_BITS) | APB_DW'(thr));
        apb_write(REG_GESTURE_MIN, ($urandom() << DIST_BITS) | APB_DW'(gmin));
        cfg_thr = thr;
        cfg_gmin = gmin;
        n_settings++;
        check_reg(REG_MOVE_THRESHOLD, APB_DW'(thr));
        check_reg(REG_GESTURE_MIN, APB_DW'(gmin));
    endtask

    // drop valid, let every owed event come out, then a few quiet cycles
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COORD_MASK;
            default: return coord_t'($urandom_range(0, int'(COORD_MASK)));
        endcase
    endfunction

    // random step around the move threshold, now and then a long jump
    function automatic coord_t walk_coord(input coord_t c);
        int step;
        int pos;
        case ($urandom_range(0, 9))
            0:       step = $urandom_range(0, 6000);
            1, 2:    step = int'(cfg_thr) + $urandom_range(0, 1);
            default: step = $urandom_range(0, 2 * int'(cfg_thr) + 8);
        endcase
        pos = $urandom_range(0, 1) ? int'(c) + step : int'(c) - step;
        if (pos < 0)
        begin
            pos = 0;
        end
        if (pos > int'(COORD_MASK))
        begin
            pos = int'(COORD_MASK);
        end
        return coord_t'(pos);
    endfunction

    // mostly whole swipes (press, holds, release), the rest stray samples
    task automatic run_swipes(input int target);
        int     goal;
        int     holds;
        coord_t px;
        coord_t py;
        goal = n_live + target;
        while (n_live < goal)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    send_touch(1'($urandom_range(0, 1)), pick_coord(), pick_coord());
                end
                3:
                begin
                    send_touch(1'b0, pick_coord(), pick_coord());
                end
                default:
                begin
                    px = pick_coord();
                    py = pick_coord();
                    send_touch(1'b1, px, py);
                    holds = $urandom_range(0, 6);
                    repeat (holds)
                    begin
                        px = walk_coord(px);
                        py = walk_coord(py);
                        send_touch(1'b1, px, py);
                    end
                    px = walk_coord(px);
                    py = walk_coord(py);
                    send_touch(1'b0, px, py);
                end
            endcase
        end
    endtask

    // event receiver: random stalls, a long hold-off on request, none when calm
    initial
    begin
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        event_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asks)
            begin
                hold_done = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                event_ch.ready <= 1'b0;
            end
            else
            begin
                event_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // event checker and watchdog on quiet cycles
    always @(posedge clk)
    begin
        res_t   want;
        int     quiet;
        if (rst_n)
        begin
            if (event_ch.valid && event_ch.ready)
            begin
                n_events++;
                if (event_ch.event_kind == EV_GESTURE)
                begin
                    n_gestures++;
                    dirs_seen[event_ch.direction] = 1'b1;
                end
                if (pending_events.size() == 0)
                begin
                    report($sformatf("event %0d (kind %0d) with none expected",
                                     n_events, event_ch.event_kind));
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_kind", 32'(event_ch.event_kind), 32'(want.kind));
                    check_field("direction", 32'(event_ch.direction), 32'(want.dir));
                    check_field("point_x", 32'(event_ch.point_x), 32'(want.x));
                    check_field("point_y", 32'(event_ch.point_y), 32'(want.y));
                    check_field("slot", 32'(event_ch.slot), 32'(want.slot));
                    check_field("last", 32'(event_ch.last), 32'(want.last));
                end
            end
            if ((sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t timeout: no beat for %0d cycles, %0d events owed",
                         $time, quiet, pending_events.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.touching <= 1'b0;
        sample_ch.touch_x <= '0;
        sample_ch.touch_y <= '0;

        trk_down = 1'b0;
        trk_prev_x = COORD_MASK;
        trk_prev_y = COORD_MASK;
        trk_start_x = COORD_MASK;
        trk_start_y = COORD_MASK;
        trk_count = 0;
        ring_tail = '0;
        ring_head = '0;
        cfg_thr = THR_RESET;
        cfg_gmin = DIST_RESET;
        n_errors = 0;
        n_samples = 0;
        n_live = 0;
        n_events = 0;
        n_gestures = 0;
        n_settings = 0;
        dirs_seen = '0;
        hold_asks = 0;
        calm = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults after reset
        check_reg(REG_MOVE_THRESHOLD, APB_DW'(THR_RESET));
        check_reg(REG_GESTURE_MIN, APB_DW'(DIST_RESET));

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (i == ZERO_CFG_ROW)
            begin
                wait_drained();
                set_config('0, '0);
            end
            send_touch(touch_rows[i].dn, touch_rows[i].x, touch_rows[i].y,
                       touch_rows[i].mode, touch_rows[i].want);
        end
        wait_drained();

        // widest settings: moves need steps over 255, no swipe reaches 32767
        set_config(8'hFF, 15'h7FFF);
        run_swipes(SWIPES_PER_PHASE);
        wait_drained();

        // any hold step on both axes is a move, every release of a touch is a gesture
        set_config('0, '0);
        run_swipes(SWIPES_PER_PHASE);
        wait_drained();

        // defaults again, with the receiver holding off so the block backs up
        set_config(THR_RESET, DIST_RESET);
        hold_asks++;
        run_swipes(SWIPES_PER_PHASE);
        wait_drained();

        // small random settings, no idling on either side
        calm = 1'b1;
        set_config(THR_BITS'($urandom_range(0, 6)), DIST_BITS'($urandom_range(0, 200)));
        run_swipes(SWIPES_PER_PHASE);
        wait_drained();
        calm = 1'b0;

        set_config(THR_BITS'($urandom_range(0, 40)), DIST_BITS'($urandom_range(0, 4000)));
        run_swipes(SWIPES_PER_PHASE);
        wait_drained();

        $display("%0d touch samples (%0d not ignored) and %0d events checked over %0d settings",
                 n_samples, n_live, n_events, n_settings);
        $display("%0d swipe gestures, directions seen %b, one %0d-cycle receiver hold-off",
                 n_gestures, dirs_seen, HOLD_CYCLES);
        if (n_errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tsd_pkg.sv
src/tsd_if.sv
src/tsd_core.sv
src/touch_event_and_swipe_detector.sv
test/tb_top.sv
